FILE: sv/smx_pkg.sv
package smx_pkg;

	localparam int DATA_W = 32;
	localparam int OP_W = 4;
	localparam int SLOT_W = 4;
	localparam int TARGET_W = 8;
	localparam int DEPTH_OUT_W = 5;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int VAR_SLOTS_DEF = 16;

	// Entries in the queue between front and back; a power of two.
	localparam int QDEPTH = 2;

	localparam logic [OP_W-1:0] OP_PUSH  = 4'd0;
	localparam logic [OP_W-1:0] OP_ADD   = 4'd1;
	localparam logic [OP_W-1:0] OP_SUB   = 4'd2;
	localparam logic [OP_W-1:0] OP_MUL   = 4'd3;
	localparam logic [OP_W-1:0] OP_WRITE = 4'd4;
	localparam logic [OP_W-1:0] OP_READ  = 4'd5;
	localparam logic [OP_W-1:0] OP_JZ    = 4'd6;
	localparam logic [OP_W-1:0] OP_JMP   = 4'd7;

	typedef enum logic [2:0] {
		K_NOP,
		K_PUSH,
		K_ARITH,
		K_WRITE,
		K_READ,
		K_JZ,
		K_JMP
	} kind_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL
	} alu_t;

	typedef struct packed {
		kind_t               kind;
		alu_t                alu;
		logic [DATA_W-1:0]   value;
		logic [SLOT_W-1:0]   slot;
		logic                slot_ok;
		logic [TARGET_W-1:0] target;
	} instr_t;

endpackage

FILE: sv/smx_front.sv
module smx_front #(
	parameter int VAR_SLOTS = smx_pkg::VAR_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [smx_pkg::OP_W-1:0]      op,
	input  logic signed [smx_pkg::DATA_W-1:0] literal_value,
	input  logic [smx_pkg::SLOT_W-1:0]    var_slot,
	input  logic [smx_pkg::TARGET_W-1:0]  target_routine,
	output logic                          q_push,
	output smx_pkg::instr_t               q_wdata,
	input  logic                          q_full
);
	import smx_pkg::*;

	instr_t dec;
	instr_t instr_s1;
	logic   v_s1;
	logic   accept;

	always_comb begin
		dec.kind    = K_NOP;
		dec.alu     = ALU_ADD;
		dec.value   = $unsigned(literal_value);
		dec.slot    = var_slot;
		dec.slot_ok = 32'(var_slot) < 32'(VAR_SLOTS);
		dec.target  = target_routine;
		unique case (op)
			OP_PUSH:  dec.kind = K_PUSH;
			OP_ADD: begin
				dec.kind = K_ARITH;
				dec.alu  = ALU_ADD;
			end
			OP_SUB: begin
				dec.kind = K_ARITH;
				dec.alu  = ALU_SUB;
			end
			OP_MUL: begin
				dec.kind = K_ARITH;
				dec.alu  = ALU_MUL;
			end
			OP_WRITE: dec.kind = K_WRITE;
			OP_READ:  dec.kind = K_READ;
			OP_JZ:    dec.kind = K_JZ;
			OP_JMP:   dec.kind = K_JMP;
			default:  dec.kind = K_NOP;
		endcase
	end

	assign in_stall = v_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign q_push   = v_s1 && !q_full;
	assign q_wdata  = instr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (q_push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1 <= dec;
		end
	end

endmodule

FILE: sv/smx_queue.sv
module smx_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  smx_pkg::instr_t wdata,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output smx_pkg::instr_t rdata
);
	import smx_pkg::*;

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);

	instr_t             mem_q [QDEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_push;
	logic               do_pop;

	assign full    = cnt_q == CNT_W'(QDEPTH);
	assign valid   = cnt_q != '0;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// The fill count never runs past the number of entries.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QDEPTH))
		else $error("queue fill count out of range");

	// A push into a full queue is never offered by the front.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push offered to a full queue");

	// The pointers stay apart by exactly the fill count.
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == CNT_W'(QDEPTH)) || (cnt_q == '0) ||
		(PTR_W'(wr_ptr_q - rd_ptr_q) == PTR_W'(cnt_q)))
		else $error("queue pointers disagree with fill count");

endmodule

FILE: sv/smx_back.sv
module smx_back #(
	parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
	parameter int VAR_SLOTS   = smx_pkg::VAR_SLOTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_valid,
	input  smx_pkg::instr_t                    q_rdata,
	output logic                               q_pop,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               jump_taken,
	output logic [smx_pkg::TARGET_W-1:0]       jump_target,
	output logic signed [smx_pkg::DATA_W-1:0]  top_value,
	output logic [smx_pkg::DEPTH_OUT_W-1:0]    stack_depth,
	output logic signed [smx_pkg::DATA_W-1:0]  var_value,
	output logic                               overflow
);
	import smx_pkg::*;

	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int VIDX_W = (VAR_SLOTS > 1) ? $clog2(VAR_SLOTS) : 1;

	typedef enum logic [1:0] {
		SH_HOLD,
		SH_PUSH,
		SH_POP,
		SH_POPLOAD
	} shift_t;

	logic [DATA_W-1:0]      stk_q [STACK_DEPTH];
	logic [DATA_W-1:0]      stk_n [STACK_DEPTH];
	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       cnt_n;
	logic [DATA_W-1:0]      var_q [VAR_SLOTS];

	logic                   fire;
	instr_t                 ins;
	logic                   has1;
	logic                   has2;
	logic                   full;
	logic [DATA_W-1:0]      opa;
	logic [DATA_W-1:0]      opb;
	logic [DATA_W-1:0]      alu_res;
	logic [VIDX_W-1:0]      vidx;
	logic [DATA_W-1:0]      var_rd;
	logic                   var_we;
	shift_t                 sh;
	logic [DATA_W-1:0]      new_top;
	logic                   jmp_n;
	logic                   ovf_n;

	logic                   out_v_q;
	logic                   jmp_q;
	logic [TARGET_W-1:0]    tgt_q;
	logic [DATA_W-1:0]      top_q;
	logic [DEPTH_OUT_W-1:0] depth_q;
	logic [DATA_W-1:0]      varv_q;
	logic                   ovf_q;

	assign ins   = q_rdata;
	assign q_pop = q_valid && (!out_v_q || !out_stall);
	assign fire  = q_pop;

	assign has1 = cnt_q != '0;
	assign has2 = cnt_q > CNT_W'(1);
	assign full = cnt_q == CNT_W'(STACK_DEPTH);
	assign opa  = has1 ? stk_q[0] : '0;
	assign opb  = has2 ? stk_q[1] : '0;
	assign vidx = VIDX_W'(ins.slot);

	assign var_rd = ins.slot_ok ? var_q[vidx] : '0;
	assign var_we = (ins.kind == K_WRITE) && ins.slot_ok;

	always_comb begin
		case (ins.alu)
			ALU_ADD: alu_res = opb + opa;
			ALU_SUB: alu_res = opb - opa;
			ALU_MUL: alu_res = opb * opa;
			default: alu_res = '0;
		endcase
	end

	always_comb begin
		sh      = SH_HOLD;
		new_top = alu_res;
		cnt_n   = cnt_q;
		jmp_n   = 1'b0;
		ovf_n   = 1'b0;
		unique case (ins.kind) inside
			K_PUSH, K_READ: begin
				new_top = (ins.kind == K_PUSH) ? ins.value : var_rd;
				if (full) begin
					ovf_n = 1'b1;
				end else begin
					sh    = SH_PUSH;
					cnt_n = cnt_q + CNT_W'(1);
				end
			end
			K_ARITH: begin
				sh    = SH_POPLOAD;
				cnt_n = has2 ? (cnt_q - CNT_W'(1)) : CNT_W'(1);
			end
			K_WRITE: begin
				sh    = SH_POP;
				cnt_n = has1 ? (cnt_q - CNT_W'(1)) : '0;
			end
			K_JZ: begin
				if (!has1 || (stk_q[0] == '0)) begin
					jmp_n = 1'b1;
					cnt_n = '0;
				end
			end
			K_JMP: begin
				jmp_n = 1'b1;
				cnt_n = '0;
			end
			default: begin
				sh = SH_HOLD;
			end
		endcase
	end

	always_comb begin
		stk_n = stk_q;
		case (sh) inside
			SH_PUSH: begin
				stk_n[0] = new_top;
				for (int i = 1; i < STACK_DEPTH; i++) begin
					stk_n[i] = stk_q[i-1];
				end
			end
			SH_POP, SH_POPLOAD: begin
				for (int i = 0; i < STACK_DEPTH - 1; i++) begin
					stk_n[i] = stk_q[i+1];
				end
				if (sh == SH_POPLOAD) begin
					stk_n[0] = new_top;
				end
			end
			default: begin
				stk_n = stk_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int i = 0; i < VAR_SLOTS; i++) begin
				var_q[i] <= '0;
			end
		end else if (fire) begin
			cnt_q <= cnt_n;
			if (var_we) begin
				var_q[vidx] <= opa;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			stk_q <= stk_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (fire) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			jmp_q   <= jmp_n;
			tgt_q   <= jmp_n ? ins.target : '0;
			top_q   <= (cnt_n == '0) ? '0 : stk_n[0];
			depth_q <= DEPTH_OUT_W'(cnt_n);
			varv_q  <= var_we ? opa : var_rd;
			ovf_q   <= ovf_n;
		end
	end

	assign out_valid   = out_v_q;
	assign jump_taken  = jmp_q;
	assign jump_target = tgt_q;
	assign top_value   = $signed(top_q);
	assign stack_depth = depth_q;
	assign var_value   = $signed(varv_q);
	assign overflow    = ovf_q;

	// The stack pointer never passes the stack size.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond stack size");

	// A held result always reports the depth the stack is left at.
	a_depth_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (depth_q == DEPTH_OUT_W'(cnt_q)))
		else $error("reported depth disagrees with stack count");

	// A dropped push leaves a full stack behind it.
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && ovf_q) |-> (cnt_q == CNT_W'(STACK_DEPTH)))
		else $error("overflow reported on a stack that is not full");

	// A taken jump always empties the stack.
	a_jump_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && jmp_n) |=> (cnt_q == '0))
		else $error("taken jump left entries on the stack");

endmodule

FILE: sv/stack_machine_executor.sv
// Results pass the front register, the queue and the back output register.
// Throughput: one instruction per cycle while the output is not stalled; the
// back part updates the stack top and count together, which sets that figure.
// Reset: arst_n clears all valid flags and the queue, empties the operand stack
// and clears every variable to zero; no clearing pass is needed.
module stack_machine_executor #(
	parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
	parameter int VAR_SLOTS   = smx_pkg::VAR_SLOTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [smx_pkg::OP_W-1:0]           op,
	input  logic signed [smx_pkg::DATA_W-1:0]  literal_value,
	input  logic [smx_pkg::SLOT_W-1:0]         var_slot,
	input  logic [smx_pkg::TARGET_W-1:0]       target_routine,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               jump_taken,
	output logic [smx_pkg::TARGET_W-1:0]       jump_target,
	output logic signed [smx_pkg::DATA_W-1:0]  top_value,
	output logic [smx_pkg::DEPTH_OUT_W-1:0]    stack_depth,
	output logic signed [smx_pkg::DATA_W-1:0]  var_value,
	output logic                               overflow
);
	import smx_pkg::*;

	// The front part registers each input transfer and decodes the opcode
	// into an instruction class, an ALU operation and a range check on the
	// variable slot. Its stall depends only on its own register and on the
	// queue being full, so it never looks at the input valid.
	logic   q_push;
	instr_t q_wdata;
	logic   q_full;
	logic   q_valid;
	logic   q_pop;
	instr_t q_rdata;

	smx_front #(
		.VAR_SLOTS(VAR_SLOTS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.literal_value (literal_value),
		.var_slot      (var_slot),
		.target_routine(target_routine),
		.q_push        (q_push),
		.q_wdata       (q_wdata),
		.q_full        (q_full)
	);

	// A short queue of decoded instructions decouples the two halves, so a
	// stalled output does not immediately push back on the input side.
	smx_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.valid (q_valid),
		.rdata (q_rdata)
	);

	// The back part holds the operand stack as a shift stack with the top
	// at entry zero, plus the variable table. It executes one instruction
	// whenever its output register is free or being drained by a transfer,
	// and loads the full result into that register in the same cycle.
	smx_back #(
		.STACK_DEPTH(STACK_DEPTH),
		.VAR_SLOTS  (VAR_SLOTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_rdata    (q_rdata),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.jump_taken (jump_taken),
		.jump_target(jump_target),
		.top_value  (top_value),
		.stack_depth(stack_depth),
		.var_value  (var_value),
		.overflow   (overflow)
	);

endmodule

FILE: sim/tb_stack_machine_executor.sv
module tb_stack_machine_executor;
	import smx_pkg::*;

	// The "none" range of opcodes: the block must leave all state alone for these.
	localparam logic [OP_W-1:0] OP_NONE_LO = 4'd8;
	localparam logic [OP_W-1:0] OP_NONE_HI = 4'd15;
	localparam logic [OP_W-1:0] ARITH_OPS [3] = '{OP_ADD, OP_SUB, OP_MUL};

	localparam logic [DATA_W-1:0] MOST_NEGATIVE = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [DATA_W-1:0] MOST_POSITIVE = {1'b0, {(DATA_W-1){1'b1}}};

	// Random items per idling phase, and the idling percentages of each phase.
	localparam int RUN_ITEMS = 388;
	localparam int PHASES = 4;
	localparam int SEND_IDLE_PCT [PHASES] = '{0, 58, 0, 29};
	localparam int RECV_STALL_PCT [PHASES] = '{0, 0, 58, 29};
	// A result passes the front register, the queue and the output register; this is
	// enough margin to catch a stray result after the last expected one.
	localparam int DRAIN_CYCLES = 12;

	typedef struct {
		logic [OP_W-1:0]          op;
		logic signed [DATA_W-1:0] literal;
		logic [SLOT_W-1:0]        slot;
		logic [TARGET_W-1:0]      target;
	} instr_item_t;

	typedef struct {
		logic                       jump_taken;
		logic [TARGET_W-1:0]        jump_target;
		logic signed [DATA_W-1:0]   top_value;
		logic [DEPTH_OUT_W-1:0]     stack_depth;
		logic signed [DATA_W-1:0]   var_value;
		logic                       overflow;
	} exec_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [OP_W-1:0] op = '0;
	logic signed [DATA_W-1:0] literal_value = '0;
	logic [SLOT_W-1:0] var_slot = '0;
	logic [TARGET_W-1:0] target_routine = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic jump_taken;
	logic [TARGET_W-1:0] jump_target;
	logic signed [DATA_W-1:0] top_value;
	logic [DEPTH_OUT_W-1:0] stack_depth;
	logic signed [DATA_W-1:0] var_value;
	logic overflow;

	stack_machine_executor dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.literal_value  (literal_value),
		.var_slot       (var_slot),
		.target_routine (target_routine),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.jump_taken     (jump_taken),
		.jump_target    (jump_target),
		.top_value      (top_value),
		.stack_depth    (stack_depth),
		.var_value      (var_value),
		.overflow       (overflow)
	);

	always #10 clk = ~clk;

	// Reset is released on a falling edge with a nonblocking write, so every
	// process sees the same order of events.
	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#4000000;
		$display("stack_machine_executor verification failed");
		$finish;
	end

	// Instructions waiting to be driven, and the expected results of those
	// already transferred, oldest first.
	instr_item_t instr_queue[$];
	exec_result_t expected_results[$];
	int queued_count = 0;
	int accepted_count = 0;
	int mismatch_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit input_taken = 1'b0;

	// Shadow copy of the machine state, advanced once per transferred instruction.
	logic [DATA_W-1:0] operand_mem [STACK_DEPTH_DEF];
	logic [DATA_W-1:0] var_mem [VAR_SLOTS_DEF] = '{default: '0};
	int stack_fill = 0;

	function automatic bit push_operand(logic [DATA_W-1:0] value);
		if (stack_fill >= STACK_DEPTH_DEF)
			return 1'b0;
		operand_mem[stack_fill] = value;
		stack_fill++;
		return 1'b1;
	endfunction

	// An empty stack reads as zero and stays empty.
	function automatic logic [DATA_W-1:0] pop_operand();
		if (stack_fill == 0)
			return '0;
		stack_fill--;
		return operand_mem[stack_fill];
	endfunction

	// Runs one instruction on the shadow state and records the result it should give.
	function automatic void execute_instr(instr_item_t item);
		logic [DATA_W-1:0] lhs;
		logic [DATA_W-1:0] rhs;
		logic jumped;
		logic dropped;
		exec_result_t res;
		jumped = 1'b0;
		dropped = 1'b0;
		case (item.op) inside
			OP_PUSH: dropped = !push_operand(item.literal);
			OP_ADD, OP_SUB, OP_MUL: begin
				rhs = pop_operand();
				lhs = pop_operand();
				if (item.op == OP_ADD)
					void'(push_operand(lhs + rhs));
				else if (item.op == OP_SUB)
					void'(push_operand(lhs - rhs));
				else
					void'(push_operand(lhs * rhs));
			end
			OP_WRITE: var_mem[item.slot] = pop_operand();
			OP_READ: dropped = !push_operand(var_mem[item.slot]);
			OP_JZ: begin
				if (stack_fill == 0 || operand_mem[stack_fill-1] == '0) begin
					stack_fill = 0;
					jumped = 1'b1;
				end
			end
			OP_JMP: begin
				stack_fill = 0;
				jumped = 1'b1;
			end
			default: ;
		endcase
		res.jump_taken = jumped;
		res.jump_target = jumped ? item.target : '0;
		res.top_value = (stack_fill == 0) ? '0 : operand_mem[stack_fill-1];
		res.stack_depth = DEPTH_OUT_W'(stack_fill);
		res.var_value = var_mem[item.slot];
		res.overflow = dropped;
		expected_results.insert(expected_results.size(), res);
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Driver: a new instruction goes out only when the previous one was
	// transferred or nothing was offered, so a stalled payload holds still.
	always @(negedge clk) begin
		instr_item_t nxt;
		if (arst_n) begin
			if (!in_valid || input_taken) begin
				if (instr_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = instr_queue.pop_front();
					op <= nxt.op;
					literal_value <= nxt.literal;
					var_slot <= nxt.slot;
					target_routine <= nxt.target;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Monitor: predicts on each input transfer, then checks each result transfer.
	always @(posedge clk) begin
		instr_item_t item;
		exec_result_t want;
		input_taken = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				item.op = op;
				item.literal = literal_value;
				item.slot = var_slot;
				item.target = target_routine;
				execute_instr(item);
				input_taken = 1'b1;
				accepted_count++;
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with no instruction waiting for it");
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("jump_taken", want.jump_taken, jump_taken);
					check_field("jump_target", want.jump_target, jump_target);
					check_field("top_value", want.top_value, top_value);
					check_field("stack_depth", want.stack_depth, stack_depth);
					check_field("var_value", want.var_value, var_value);
					check_field("overflow", want.overflow, overflow);
				end
			end
		end
	end

	function automatic void queue_instr(logic [OP_W-1:0] code, logic [DATA_W-1:0] lit,
			logic [SLOT_W-1:0] slot, logic [TARGET_W-1:0] target);
		instr_item_t item;
		item.op = code;
		item.literal = lit;
		item.slot = slot;
		item.target = target;
		instr_queue.insert(instr_queue.size(), item);
		queued_count++;
	endfunction

	// Literals lean on the corner values: zero makes jump-if-zero fire.
	function automatic logic [DATA_W-1:0] pick_literal();
		case ($urandom_range(0, 9)) inside
			0: return '0;
			1: return MOST_NEGATIVE;
			2: return MOST_POSITIVE;
			3: return '1;
			4, 5: return DATA_W'($urandom_range(0, 15));
			default: return $urandom();
		endcase
	endfunction

	function automatic void queue_with_random_fields(logic [OP_W-1:0] code);
		queue_instr(code, pick_literal(), SLOT_W'($urandom()), TARGET_W'($urandom()));
	endfunction

	// One random run: pushes and reads build the stack up (often to full), or
	// arithmetic or writes consume it, or a jump or an unused opcode is sent.
	function automatic void queue_random_run();
		int pick;
		int len;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			len = $urandom_range(1, 20);
			repeat (len) begin
				if ($urandom_range(0, 3) == 0)
					queue_with_random_fields(OP_READ);
				else
					queue_with_random_fields(OP_PUSH);
			end
		end else if (pick < 70) begin
			len = $urandom_range(1, 6);
			repeat (len)
				queue_with_random_fields(ARITH_OPS[$urandom_range(0, 2)]);
		end else if (pick < 85) begin
			len = $urandom_range(1, 3);
			repeat (len)
				queue_with_random_fields(OP_WRITE);
		end else if (pick < 95) begin
			queue_with_random_fields($urandom_range(0, 2) != 0 ? OP_JZ : OP_JMP);
		end else begin
			queue_with_random_fields(OP_W'($urandom_range(OP_NONE_LO, OP_NONE_HI)));
		end
	endfunction

	task automatic wait_all_taken();
		while (accepted_count != queued_count)
			@(negedge clk);
	endtask

	initial begin
		int start_count;

		// Directed part: fill the stack to the brim with nonzero values, the two
		// extremes last, then hit overflow on push and read, add the two extremes and
		// walk through write, the jumps and an unused opcode.
		repeat (14)
			queue_instr(OP_PUSH, $urandom() | 32'd1, SLOT_W'($urandom()), '0);
		queue_instr(OP_PUSH, MOST_POSITIVE, '0, '0);
		queue_instr(OP_PUSH, MOST_NEGATIVE, '1, '1);
		queue_instr(OP_PUSH, 32'h1234_5678, 4'd1, '0);
		queue_instr(OP_READ, '0, 4'd3, '0);
		queue_instr(OP_ADD, '0, '0, '0);
		queue_instr(OP_MUL, '0, '0, '0);
		queue_instr(OP_WRITE, '0, '1, '0);
		// The top is nonzero here, so this jump must not be taken.
		queue_instr(OP_JZ, '0, '1, 8'hA5);
		queue_instr(OP_READ, '0, '0, '0);
		queue_instr(OP_JZ, '0, '0, '1);
		// Write on an empty stack stores zero, then jump-if-zero on empty fires.
		queue_instr(OP_WRITE, '1, '0, '0);
		queue_instr(OP_JZ, '0, '1, 8'h3C);
		queue_instr(OP_JMP, '1, '0, '0);
		queue_instr(OP_NONE_HI, '1, '1, '1);
		wait_all_taken();

		for (int phase = 0; phase < PHASES; phase++) begin
			send_idle_pct = SEND_IDLE_PCT[phase];
			recv_stall_pct = RECV_STALL_PCT[phase];
			start_count = queued_count;
			while (queued_count - start_count < RUN_ITEMS)
				queue_random_run();
			wait_all_taken();
		end

		// Let the receiver drain without stalls, then watch for stray results.
		recv_stall_pct = 0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatch_count == 0)
			$display("stack_machine_executor verification clean");
		else
			$display("stack_machine_executor verification failed");
		$finish;
	end

endmodule
